// ----- sv/cpd_pkg.sv -----
// Shared types, constants and the arctangent table for the polar converter.
package cpd_pkg;

    // Datapath widths: x and y carry 16 fractional bits, z is degrees with 16 fractional bits.
    localparam int XW = 36;
    localparam int ZW = 27;
    localparam int PW = 64;
    localparam int MW = 34;

    localparam logic [29:0]          INV_GAIN_Q30 = 30'd652032874;
    localparam logic signed [ZW-1:0] DEG180       = 27'sd11796480;
    localparam logic signed [ZW-1:0] DEG360       = 27'sd23592960;
    localparam logic [17:0]          RADIUS_MAX   = 18'd185364;
    localparam logic [16:0]          ANGLE_WRAP   = 17'd46080;

    typedef struct packed {
        logic                 zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cord;

    // atan(2^-i) in degrees, scaled by 65536 and rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_deg(input int unsigned idx);
        logic [22:0] v;
        case (idx)
            0:       v = 23'd2949120;
            1:       v = 23'd1740967;
            2:       v = 23'd919879;
            3:       v = 23'd466945;
            4:       v = 23'd234379;
            5:       v = 23'd117304;
            6:       v = 23'd58666;
            7:       v = 23'd29335;
            8:       v = 23'd14668;
            9:       v = 23'd7334;
            10:      v = 23'd3667;
            11:      v = 23'd1833;
            12:      v = 23'd917;
            13:      v = 23'd458;
            14:      v = 23'd229;
            15:      v = 23'd115;
            16:      v = 23'd57;
            17:      v = 23'd29;
            18:      v = 23'd14;
            19:      v = 23'd7;
            20:      v = 23'd4;
            21:      v = 23'd2;
            22:      v = 23'd1;
            default: v = 23'd0;
        endcase
        return $signed({{(ZW-23){1'b0}}, v});
    endfunction

endpackage

// ----- sv/cpd_if.sv -----
// Handshake interfaces for the point input channel and the polar result channel.
interface cpd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] coord_x;
    logic [15:0] coord_y;

    modport source (output valid, output coord_x, output coord_y, input ready);
    modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

interface cpd_out_if;
    logic        valid;
    logic        ready;
    logic [17:0] radius;
    logic [15:0] angle_deg;

    modport source (output valid, output radius, output angle_deg, input ready);
    modport sink   (input valid, input radius, input angle_deg, output ready);
endinterface

// ----- sv/cpd_cell.sv -----
// One CORDIC vectoring micro-rotation stage with its own pipeline register.
module cpd_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  cpd_pkg::t_cord i_data,
    output logic           o_valid,
    output cpd_pkg::t_cord o_data
);

    logic                          r_valid;
    cpd_pkg::t_cord                r_data;
    cpd_pkg::t_cord                n_data;
    logic signed [cpd_pkg::XW-1:0] xs;
    logic signed [cpd_pkg::XW-1:0] ys;

    // Arithmetic shifts round towards minus infinity, as the rotation requires.
    assign xs = i_data.x >>> IDX;
    assign ys = i_data.y >>> IDX;

    always_comb begin
        n_data = i_data;
        if (i_data.y[cpd_pkg::XW-1]) begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - cpd_pkg::atan_deg(IDX);
        end else begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + cpd_pkg::atan_deg(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- sv/cpd_post.sv -----
// Gain correction, angle wrap and rounding, ending in the output register.
module cpd_post (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  cpd_pkg::t_cord i_data,
    output logic           o_valid,
    output logic [17:0]    o_radius,
    output logic [15:0]    o_angle_deg
);

    logic                          r_mul_valid;
    logic [cpd_pkg::PW-1:0]        r_prod;
    logic [24:0]                   r_zw;
    logic                          r_zero;
    logic signed [cpd_pkg::ZW-1:0] n_zw;

    logic                          r_out_valid;
    logic [17:0]                   r_radius;
    logic [15:0]                   r_angle;
    logic [cpd_pkg::PW:0]          rad_sum;
    logic [20:0]                   rad_q;
    logic [17:0]                   n_radius;
    logic [25:0]                   ang_sum;
    logic [16:0]                   ang_q;
    logic [16:0]                   ang_w;

    // The accumulator never falls below minus 100 degrees, so one add wraps it.
    assign n_zw = i_data.z[cpd_pkg::ZW-1] ? i_data.z + cpd_pkg::DEG360 : i_data.z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (i_en) begin
            r_mul_valid <= i_valid;
        end
    end

    // x is non-negative after the fold, so its low bits multiply as unsigned.
    // Both operands are widened first so that the full product is kept.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= cpd_pkg::PW'(i_data.x[cpd_pkg::MW-1:0])
                    * cpd_pkg::PW'(cpd_pkg::INV_GAIN_Q30);
            r_zw   <= n_zw[24:0];
            r_zero <= i_data.zero;
        end
    end

    always_comb begin
        rad_sum  = {1'b0, r_prod} + (65'd1 << 43);
        rad_q    = rad_sum[64:44];
        n_radius = (rad_q > 21'(cpd_pkg::RADIUS_MAX)) ? cpd_pkg::RADIUS_MAX : rad_q[17:0];
        ang_sum  = {1'b0, r_zw} + 26'd256;
        ang_q    = ang_sum[25:9];
        ang_w    = (ang_q >= cpd_pkg::ANGLE_WRAP) ? ang_q - cpd_pkg::ANGLE_WRAP : ang_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_radius <= r_zero ? 18'd0 : n_radius;
            r_angle  <= r_zero ? 16'd0 : ang_w[15:0];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_radius    = r_radius;
    assign o_angle_deg = r_angle;

endmodule

// ----- sv/cartesian_to_polar_degrees.sv -----
// Top level: Cartesian to polar converter in degrees, a pipelined CORDIC row.
//
//  Channel   Direction  Fields                           Handshake
//  i_pt      in         coord_x[15:0], coord_y[15:0]     valid/ready
//  o_pol     out        radius[17:0], angle_deg[15:0]    valid/ready
//
// One item enters per clock unless stalled; each goes through a fold register,
// one cell per micro-rotation, a multiply register and the output register.
// The whole row advances together whenever the output register is empty or
// being taken, so i_pt.ready follows o_pol.ready combinationally.
// A synchronous low reset empties every stage; payload registers keep old data.
module cartesian_to_polar_degrees #(
    parameter int ITERATIONS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cpd_in_if.sink    i_pt,
    cpd_out_if.source o_pol
);

    logic                          en;
    logic                          r_fold_valid;
    cpd_pkg::t_cord                r_fold;
    cpd_pkg::t_cord                n_fold;
    logic signed [cpd_pkg::XW-1:0] xe;
    logic signed [cpd_pkg::XW-1:0] ye;

    logic                          w_valid [0:ITERATIONS];
    cpd_pkg::t_cord                w_data  [0:ITERATIONS];

    assign en         = !o_pol.valid || o_pol.ready;
    assign i_pt.ready = en;

    assign xe = $signed({{(cpd_pkg::XW-32){i_pt.coord_x[15]}}, i_pt.coord_x, 16'd0});
    assign ye = $signed({{(cpd_pkg::XW-32){i_pt.coord_y[15]}}, i_pt.coord_y, 16'd0});

    // Points in the left half plane are turned by 180 degrees first.
    always_comb begin
        n_fold.zero = (i_pt.coord_x == 16'd0) && (i_pt.coord_y == 16'd0);
        if (i_pt.coord_x[15]) begin
            n_fold.x = -xe;
            n_fold.y = -ye;
            n_fold.z = cpd_pkg::DEG180;
        end else begin
            n_fold.x = xe;
            n_fold.y = ye;
            n_fold.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_valid <= 1'b0;
        end else if (en) begin
            r_fold_valid <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fold <= n_fold;
        end
    end

    assign w_valid[0] = r_fold_valid;
    assign w_data[0]  = r_fold;

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
        cpd_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    cpd_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (w_valid[ITERATIONS]),
        .i_data      (w_data[ITERATIONS]),
        .o_valid     (o_pol.valid),
        .o_radius    (o_pol.radius),
        .o_angle_deg (o_pol.angle_deg)
    );

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pol.valid |-> (o_pol.angle_deg < 16'd46080))
        else $error("angle outside [0,360) degrees");

    a_radius_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pol.valid |-> (o_pol.radius <= 18'd185364))
        else $error("radius above its range");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pol.valid && !o_pol.ready) |-> !i_pt.ready)
        else $error("input taken while the output register is blocked");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pol.valid)
        else $error("result shown straight after reset");

endmodule

// ----- dv/tb_cartesian_to_polar_degrees.sv -----
// Self-checking testbench for the Cartesian to polar converter, with its own CORDIC predictor.
module tb_cartesian_to_polar_degrees;

    localparam int ITERATIONS  = 16;
    localparam int TOTAL_ITEMS = 1550;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int PAUSE_AT    = 900;
    localparam int DIRECTED_N  = 23;

    localparam longint          ONE_Q16    = 64'sd65536;
    localparam longint          HALF_TURN  = 180 * ONE_Q16;
    localparam longint          FULL_TURN  = 360 * ONE_Q16;
    localparam longint unsigned INV_GAIN   = 64'd652032874;
    localparam longint unsigned RADIUS_TOP = 64'd185364;
    localparam longint unsigned ANGLE_TOP  = 64'd46080;

    // Arctangent of 2^-i in degrees, 16 fractional bits.
    localparam longint ATAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic [17:0] radius;
        logic [15:0] angle_deg;
    } polar_t;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        bit          known;
        polar_t      want;
    } point_row_t;

    logic i_clk;
    logic i_rst_n;

    cpd_in_if  pt_if ();
    cpd_out_if pol_if ();

    cartesian_to_polar_degrees #(
        .ITERATIONS(ITERATIONS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt_if),
        .o_pol  (pol_if)
    );

    polar_t pending_polar [$];
    int     mismatches;
    int     results_seen;
    int     idle_cycles;

    // Directed points: axes, corners, unit steps and the edges of the angle wrap.
    point_row_t directed_pts [DIRECTED_N] = '{
        '{16'h0000, 16'h0000, 1'b1, '{18'd0, 16'd0}},
        '{16'h7FFF, 16'h0000, 1'b0, '{18'd0, 16'd0}},
        '{16'h8000, 16'h0000, 1'b0, '{18'd0, 16'd0}},
        '{16'h0000, 16'h7FFF, 1'b0, '{18'd0, 16'd0}},
        '{16'h0000, 16'h8000, 1'b0, '{18'd0, 16'd0}},
        '{16'h7FFF, 16'h7FFF, 1'b0, '{18'd0, 16'd0}},
        '{16'h8000, 16'h8000, 1'b0, '{18'd0, 16'd0}},
        '{16'h8000, 16'h7FFF, 1'b0, '{18'd0, 16'd0}},
        '{16'h7FFF, 16'h8000, 1'b0, '{18'd0, 16'd0}},
        '{16'h0001, 16'h0000, 1'b0, '{18'd0, 16'd0}},
        '{16'hFFFF, 16'h0000, 1'b0, '{18'd0, 16'd0}},
        '{16'h0000, 16'h0001, 1'b0, '{18'd0, 16'd0}},
        '{16'h0000, 16'hFFFF, 1'b0, '{18'd0, 16'd0}},
        '{16'h0001, 16'h0001, 1'b0, '{18'd0, 16'd0}},
        '{16'hFFFF, 16'hFFFF, 1'b0, '{18'd0, 16'd0}},
        '{16'hFFFF, 16'h0001, 1'b0, '{18'd0, 16'd0}},
        '{16'h0001, 16'hFFFF, 1'b0, '{18'd0, 16'd0}},
        '{16'h7FFF, 16'hFFFF, 1'b0, '{18'd0, 16'd0}},
        '{16'h8000, 16'hFFFF, 1'b0, '{18'd0, 16'd0}},
        '{16'h8000, 16'h0001, 1'b0, '{18'd0, 16'd0}},
        '{16'h0000, 16'h0000, 1'b1, '{18'd0, 16'd0}},
        '{16'h0003, 16'h0004, 1'b0, '{18'd0, 16'd0}},
        '{16'hFFFB, 16'h000C, 1'b0, '{18'd0, 16'd0}}
    };

    function automatic polar_t cordic_polar(input logic signed [15:0] px,
                                            input logic signed [15:0] py);
        longint          x, y, z, xs, ys;
        longint unsigned prod, rad, ang;
        int              i;
        polar_t          res;
        res.radius    = '0;
        res.angle_deg = '0;
        if (px == 0 && py == 0) begin
            return res;
        end
        x = longint'(px) * ONE_Q16;
        y = longint'(py) * ONE_Q16;
        z = 0;
        // Fold the left half plane over, starting the angle at 180 degrees.
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (i = 0; i < ITERATIONS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q16[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q16[i];
            end
        end
        prod = $unsigned(x) * INV_GAIN;
        rad  = (prod + (64'd1 << 43)) >> 44;
        if (rad > RADIUS_TOP) begin
            rad = RADIUS_TOP;
        end
        while (z < 0) z = z + FULL_TURN;
        while (z >= FULL_TURN) z = z - FULL_TURN;
        ang = ($unsigned(z) + 64'd256) >> 9;
        if (ang >= ANGLE_TOP) begin
            ang = ang - ANGLE_TOP;
        end
        res.radius    = rad[17:0];
        res.angle_deg = ang[15:0];
        return res;
    endfunction

    function automatic logic [15:0] corner_coord(input int unsigned pick);
        case (pick)
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0001;
            default: return 16'h0000;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: any cycle in which an item moves on either side resets the count.
    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (pol_if.valid && pol_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stalls, one long hold-off, and the field checks.
    initial begin
        int     stall;
        bit     stall_on;
        polar_t want;
        stall_on = 1'b1;
        pol_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (results_seen % 128 == 0) begin
                stall_on = ($urandom_range(0, 3) != 0);
            end
            stall = stall_on ? $urandom_range(0, 15) : 0;
            if (results_seen == HOLD_AT) begin
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                pol_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pol_if.ready <= 1'b1;
            do @(posedge i_clk); while (!pol_if.valid);
            if (pending_polar.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            end else begin
                want = pending_polar.pop_front();
                if (pol_if.radius !== want.radius) begin
                    report_mismatch($sformatf("result %0d radius %0d, expected %0d",
                                              results_seen, pol_if.radius, want.radius));
                end
                if (pol_if.angle_deg !== want.angle_deg) begin
                    report_mismatch($sformatf("result %0d angle_deg %0d, expected %0d",
                                              results_seen, pol_if.angle_deg,
                                              want.angle_deg));
                end
            end
            results_seen++;
        end
    end

    // Point side: reset, the directed table, then random points.
    initial begin
        int          idx;
        int          gap;
        int unsigned kind;
        bit          gap_on;
        logic [15:0] px, py, mag;
        polar_t      want;
        mismatches   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        gap_on       = 1'b1;
        i_rst_n       <= 1'b0;
        pt_if.valid   <= 1'b0;
        pt_if.coord_x <= '0;
        pt_if.coord_y <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (idx = 0; idx < TOTAL_ITEMS; idx++) begin
            if (idx < DIRECTED_N) begin
                px = directed_pts[idx].x;
                py = directed_pts[idx].y;
            end else begin
                kind = $urandom_range(0, 9);
                case (kind)
                    6: begin
                        px = 16'($urandom_range(0, 8)) - 16'd4;
                        py = 16'($urandom_range(0, 8)) - 16'd4;
                    end
                    7: begin
                        // Points on the axes and diagonals.
                        mag = 16'($urandom);
                        case ($urandom_range(0, 3))
                            0:       begin px = mag; py = '0;         end
                            1:       begin px = '0;  py = mag;        end
                            2:       begin px = mag; py = mag;        end
                            default: begin px = mag; py = 16'd0 - mag; end
                        endcase
                    end
                    8: begin
                        px = corner_coord($urandom_range(0, 4));
                        py = corner_coord($urandom_range(0, 4));
                    end
                    9: begin
                        px = '0;
                        py = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'h0000;
                    end
                    default: begin
                        px = 16'($urandom);
                        py = 16'($urandom);
                    end
                endcase
            end
            if (idx < DIRECTED_N && directed_pts[idx].known) begin
                want = directed_pts[idx].want;
            end else begin
                want = cordic_polar(px, py);
            end

            if (idx % 128 == 0) begin
                gap_on = ($urandom_range(0, 3) != 0);
            end
            gap = gap_on ? $urandom_range(0, 15) : 0;
            if (gap > 0 || idx == PAUSE_AT) begin
                pt_if.valid <= 1'b0;
                if (idx == PAUSE_AT) begin
                    do @(posedge i_clk); while (pending_polar.size() != 0);
                end
                repeat (gap) @(posedge i_clk);
            end
            pt_if.valid   <= 1'b1;
            pt_if.coord_x <= px;
            pt_if.coord_y <= py;
            do @(posedge i_clk); while (!pt_if.ready);
            pending_polar.push_back(want);
        end
        pt_if.valid <= 1'b0;

        while (pending_polar.size() != 0) @(posedge i_clk);
        repeat (ITERATIONS + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
